// ===== hw/rtl/lfpi_pkg.sv =====
// Shared types and constants for the four-point Lagrange interpolator.
// No dependencies.
`default_nettype none

package lfpi_pkg;

   localparam int COEF_FRAC = 30;
   localparam int OPER_W    = 64;
   localparam int MUL_LAT   = 3;

   localparam logic [OPER_W-1:0] COEF_ONE = OPER_W'(64'd1 << COEF_FRAC);
   localparam logic [OPER_W-1:0] COEF_CAP = OPER_W'((64'd1 << 62) - 64'd1);
   localparam logic [OPER_W-1:0] TERM_CAP = OPER_W'(64'd1 << 60);

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_SAT   = 2'd2
   } status_type;

   typedef struct packed {
      logic [OPER_W-1:0] mag;
      logic              neg;
      logic              sat;
   } term_type;

   // abscissa index used by the given factor slot of a lane (skips the lane's own)
   function automatic logic [1:0] other_index(input logic [1:0] lane, input logic [1:0] slot);
      logic [1:0] res;
      res = (slot < lane) ? slot : slot + 2'd1;
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lfpi_delay.sv =====
// Enabled shift line for sideband data traveling next to a pipelined unit.
// Depends on nothing.
`default_nettype none

module lfpi_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic [WIDTH-1:0] din,
   output logic      [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] stage_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DEPTH; s++) stage_ff[s] <= '0;
      end else if (en) begin
         stage_ff[0] <= din;
         for (int s = 1; s < DEPTH; s++) stage_ff[s] <= stage_ff[s-1];
      end
   end

   assign dout = stage_ff[DEPTH-1];

endmodule

`default_nettype wire

// ===== hw/rtl/lfpi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing.
`default_nettype none

module lfpi_div #(
   parameter int N_W = 62,
   parameter int D_W = 32
) (
   input  wire logic           clock,
   input  wire logic           en,
   input  wire logic [N_W-1:0] dividend,
   input  wire logic [D_W-1:0] divisor,
   output logic      [N_W-1:0] quotient
);

   logic [D_W-1:0] rem_ff [N_W];
   logic [N_W-1:0] acc_ff [N_W];
   logic [D_W-1:0] dvs_ff [N_W];

   for (genvar s = 0; s < N_W; s++) begin : g_stage
      logic [D_W-1:0] src_rem;
      logic [N_W-1:0] src_acc;
      logic [D_W-1:0] src_dvs;
      logic [D_W:0]   trial;
      logic [D_W:0]   diff;
      logic           ge;

      if (s == 0) begin : g_first
         assign src_rem = '0;
         assign src_acc = dividend;
         assign src_dvs = divisor;
      end else begin : g_next
         assign src_rem = rem_ff[s-1];
         assign src_acc = acc_ff[s-1];
         assign src_dvs = dvs_ff[s-1];
      end

      assign trial = {src_rem, src_acc[N_W-1]};
      assign diff  = trial - {1'b0, src_dvs};
      assign ge    = trial >= {1'b0, src_dvs};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
            acc_ff[s] <= {src_acc[N_W-2:0], ge};
            dvs_ff[s] <= src_dvs;
         end
      end
   end

   assign quotient = acc_ff[N_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/lfpi_mul.sv =====
// Three-stage 64x64 multiply with rounded right shift and magnitude cap.
// Depends on lfpi_pkg.
`default_nettype none

module lfpi_mul
   import lfpi_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [OPER_W-1:0] op_a,
   input  wire logic [OPER_W-1:0] op_b,
   input  wire logic [OPER_W-1:0] cap,
   output logic      [OPER_W-1:0] prod,
   output logic                   sat
);

   localparam int HALF = OPER_W / 2;
   localparam int FULL = 2 * OPER_W;
   localparam logic [FULL-1:0] ROUND = FULL'(1) << (COEF_FRAC - 1);

   logic [OPER_W-1:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic [OPER_W-1:0] cap1_ff, cap2_ff;
   logic [FULL-1:0]   sum_ff;
   logic [OPER_W-1:0] shifted;
   logic              over;

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff   <= OPER_W'(op_a[HALF-1:0])      * OPER_W'(op_b[HALF-1:0]);
         lh_ff   <= OPER_W'(op_a[HALF-1:0])      * OPER_W'(op_b[OPER_W-1:HALF]);
         hl_ff   <= OPER_W'(op_a[OPER_W-1:HALF]) * OPER_W'(op_b[HALF-1:0]);
         hh_ff   <= OPER_W'(op_a[OPER_W-1:HALF]) * OPER_W'(op_b[OPER_W-1:HALF]);
         cap1_ff <= cap;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff  <= FULL'(ll_ff) + (FULL'(lh_ff) << HALF) + (FULL'(hl_ff) << HALF)
                    + (FULL'(hh_ff) << OPER_W) + ROUND;
         cap2_ff <= cap1_ff;
      end
   end

   assign over    = |sum_ff[FULL-1:OPER_W+COEF_FRAC];
   assign shifted = sum_ff[OPER_W+COEF_FRAC-1:COEF_FRAC];

   always_ff @(posedge clock) begin
      if (en) begin
         if (over || (shifted > cap2_ff)) begin
            prod <= cap2_ff;
            sat  <= 1'b1;
         end else begin
            prod <= shifted;
            sat  <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lfpi_lane.sv =====
// One basis lane: three factor dividers, coefficient product chain, term.
// Depends on lfpi_pkg, lfpi_div, lfpi_mul, lfpi_delay.
`default_nettype none

module lfpi_lane
   import lfpi_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic [2:0][DATA_WIDTH-1:0] num_mag,
   input  wire logic [2:0][DATA_WIDTH-1:0] den_mag,
   input  wire logic [2:0]                 skip,
   input  wire logic                       term_neg,
   input  wire logic [DATA_WIDTH-1:0]      y_mag,
   output term_type                        term
);

   localparam int MAG_W = DATA_WIDTH;
   localparam int DVD_W = MAG_W + COEF_FRAC + 1;
   localparam int QX_W  = (DVD_W > OPER_W) ? DVD_W : OPER_W;
   localparam int S0_W  = 3 + DATA_WIDTH + 1;
   localparam int S1_W  = OPER_W + DATA_WIDTH + 2;
   localparam int S2_W  = DATA_WIDTH + 2;

   logic [2:0][DVD_W-1:0] dvd_ff;
   logic [2:0][MAG_W-1:0] dvs_ff;
   logic [2:0][DVD_W-1:0] quo;
   logic [2:0][OPER_W-1:0] factor;
   logic [2:0]            fsat;

   logic [S0_W-1:0] side0;
   logic [2:0]            skip_d;
   logic [DATA_WIDTH-1:0] ymag_d0;
   logic                  neg_d0;

   logic [S1_W-1:0]       side1;
   logic [OPER_W-1:0]     f2_d1;
   logic [DATA_WIDTH-1:0] ymag_d1;
   logic                  neg_d1, sat_d1;

   logic [S2_W-1:0]       side2;
   logic [DATA_WIDTH-1:0] ymag_d2;
   logic                  neg_d2, sat_d2;

   logic [1:0]            side3;

   logic [OPER_W-1:0] mag2, mag3, tmag;
   logic              msat1, msat2, msat3;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            dvd_ff[j] <= {1'b0, num_mag[j], COEF_FRAC'(0)} + DVD_W'(den_mag[j] >> 1);
            dvs_ff[j] <= den_mag[j];
         end
      end
   end

   for (genvar j = 0; j < 3; j++) begin : g_div
      lfpi_div #(.N_W(DVD_W), .D_W(MAG_W)) u_div (
         .clock    (clock),
         .en       (en),
         .dividend (dvd_ff[j]),
         .divisor  (dvs_ff[j]),
         .quotient (quo[j])
      );
   end

   lfpi_delay #(.WIDTH(S0_W), .DEPTH(DVD_W + 1)) u_side0 (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .din   ({skip, y_mag, term_neg}),
      .dout  (side0)
   );
   assign {skip_d, ymag_d0, neg_d0} = side0;

   always_comb begin
      logic [QX_W-1:0] q_ext;
      for (int j = 0; j < 3; j++) begin
         q_ext = QX_W'(quo[j]);
         if (skip_d[j]) begin
            factor[j] = COEF_ONE;
            fsat[j]   = 1'b0;
         end else if (q_ext > QX_W'(COEF_CAP)) begin
            factor[j] = COEF_CAP;
            fsat[j]   = 1'b1;
         end else begin
            factor[j] = q_ext[OPER_W-1:0];
            fsat[j]   = 1'b0;
         end
      end
   end

   lfpi_mul u_mul1 (
      .clock (clock), .en (en), .op_a (factor[0]), .op_b (factor[1]),
      .cap (COEF_CAP), .prod (mag2), .sat (msat1)
   );

   lfpi_delay #(.WIDTH(S1_W), .DEPTH(MUL_LAT)) u_side1 (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .din   ({factor[2], ymag_d0, neg_d0, |fsat}),
      .dout  (side1)
   );
   assign {f2_d1, ymag_d1, neg_d1, sat_d1} = side1;

   lfpi_mul u_mul2 (
      .clock (clock), .en (en), .op_a (mag2), .op_b (f2_d1),
      .cap (COEF_CAP), .prod (mag3), .sat (msat2)
   );

   lfpi_delay #(.WIDTH(S2_W), .DEPTH(MUL_LAT)) u_side2 (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .din   ({ymag_d1, neg_d1, sat_d1 | msat1}),
      .dout  (side2)
   );
   assign {ymag_d2, neg_d2, sat_d2} = side2;

   lfpi_mul u_mul3 (
      .clock (clock), .en (en), .op_a (mag3), .op_b (OPER_W'(ymag_d2)),
      .cap (TERM_CAP), .prod (tmag), .sat (msat3)
   );

   lfpi_delay #(.WIDTH(2), .DEPTH(MUL_LAT)) u_side3 (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .din   ({neg_d2, sat_d2 | msat2}),
      .dout  (side3)
   );

   assign term.mag = tmag;
   assign term.neg = side3[1];
   assign term.sat = side3[0] | msat3;

endmodule

`default_nettype wire

// ===== hw/rtl/lagrange_four_point_interpolator_top.sv =====
// Pipeline depth is set by the bit-per-stage factor dividers and three chained 3-stage multiplies.
// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// Reset: synchronous, active high; clears valid bits and min_spacing to zero.
// Top level: input register, differences, four basis lanes, term sum and clamp.
// Depends on lfpi_pkg, lfpi_lane, lfpi_delay.
`default_nettype none

module lagrange_four_point_interpolator_top
   import lfpi_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [15:0]           csr_wr_data,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [DATA_WIDTH-1:0] req_grid_x0,
   input  wire logic [DATA_WIDTH-1:0] req_grid_x1,
   input  wire logic [DATA_WIDTH-1:0] req_grid_x2,
   input  wire logic [DATA_WIDTH-1:0] req_grid_x3,
   input  wire logic [DATA_WIDTH-1:0] req_grid_y0,
   input  wire logic [DATA_WIDTH-1:0] req_grid_y1,
   input  wire logic [DATA_WIDTH-1:0] req_grid_y2,
   input  wire logic [DATA_WIDTH-1:0] req_grid_y3,
   input  wire logic [DATA_WIDTH-1:0] req_query_point,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [DATA_WIDTH-1:0]      rsp_interp_value,
   output logic [1:0]                 rsp_status
);

   localparam int DIFF_W   = DATA_WIDTH + 1;
   localparam int MAG_W    = DATA_WIDTH;
   localparam int LANE_LAT = 1 + (MAG_W + COEF_FRAC + 1) + 3 * MUL_LAT;
   localparam logic signed [OPER_W-1:0] SUM_HI =
      (OPER_W'(64'sd1) <<< (DATA_WIDTH - 1)) - OPER_W'(64'sd1);
   localparam logic signed [OPER_W-1:0] SUM_LO = -SUM_HI - OPER_W'(64'sd1);

   logic en;
   logic [15:0] min_spacing_ff;

   logic signed [3:0][DATA_WIDTH-1:0] x_ff, y_ff;
   logic signed [DATA_WIDTH-1:0]      a_ff;
   logic                              v0_ff;

   logic [3:0][2:0][MAG_W-1:0] num_mag_ff, num_mag_in;
   logic [3:0][2:0][MAG_W-1:0] den_mag_ff, den_mag_in;
   logic [3:0][2:0]            skip_ff, skip_in;
   logic [3:0]                 tneg_ff, tneg_in;
   logic [3:0][DATA_WIDTH-1:0] ymag_ff, ymag_in;
   logic                       v1_ff, oor1_ff, oor1_in;

   term_type [3:0] term;
   logic [1:0]     vl_out;

   logic signed [OPER_W-1:0] sum_ff, sum_in;
   logic                     sum_sat_ff, sum_oor_ff, sum_valid_ff;

   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_spacing_ff <= '0;
      end else if (csr_wr_en) begin
         min_spacing_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= {req_grid_x3, req_grid_x2, req_grid_x1, req_grid_x0};
         y_ff <= {req_grid_y3, req_grid_y2, req_grid_y1, req_grid_y0};
         a_ff <= req_query_point;
      end
   end

   always_comb begin
      logic [1:0]               k;
      logic signed [DIFF_W-1:0] num_d, den_d;
      logic                     neg;
      logic signed [DIFF_W-1:0] y_d;
      oor1_in = (a_ff < $signed(x_ff[1])) || (a_ff > $signed(x_ff[2]));
      for (int i = 0; i < 4; i++) begin
         neg = 1'b0;
         for (int j = 0; j < 3; j++) begin
            k     = other_index(2'(i), 2'(j));
            num_d = DIFF_W'(a_ff) - DIFF_W'($signed(x_ff[k]));
            den_d = DIFF_W'($signed(x_ff[i])) - DIFF_W'($signed(x_ff[k]));
            num_mag_in[i][j] = num_d[DIFF_W-1] ? MAG_W'(-num_d) : MAG_W'(num_d);
            den_mag_in[i][j] = den_d[DIFF_W-1] ? MAG_W'(-den_d) : MAG_W'(den_d);
            skip_in[i][j]    = den_mag_in[i][j] <= MAG_W'(min_spacing_ff);
            if (!skip_in[i][j] && (num_d != '0) && (num_d[DIFF_W-1] != den_d[DIFF_W-1]))
               neg = !neg;
         end
         y_d        = DIFF_W'($signed(y_ff[i]));
         ymag_in[i] = y_d[DIFF_W-1] ? DATA_WIDTH'(-y_d) : DATA_WIDTH'(y_d);
         tneg_in[i] = neg ^ y_ff[i][DATA_WIDTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_mag_ff <= num_mag_in;
         den_mag_ff <= den_mag_in;
         skip_ff    <= skip_in;
         tneg_ff    <= tneg_in;
         ymag_ff    <= ymag_in;
         oor1_ff    <= oor1_in;
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_lane
      lfpi_lane #(.DATA_WIDTH(DATA_WIDTH)) u_lane (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .num_mag  (num_mag_ff[i]),
         .den_mag  (den_mag_ff[i]),
         .skip     (skip_ff[i]),
         .term_neg (tneg_ff[i]),
         .y_mag    (ymag_ff[i]),
         .term     (term[i])
      );
   end

   lfpi_delay #(.WIDTH(2), .DEPTH(LANE_LAT)) u_ctl_delay (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .din   ({v1_ff, oor1_ff}),
      .dout  (vl_out)
   );

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < 4; i++) begin
         if (term[i].neg) sum_in = sum_in - $signed(term[i].mag);
         else             sum_in = sum_in + $signed(term[i].mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (en) begin
         sum_valid_ff <= vl_out[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff     <= sum_in;
         sum_oor_ff <= vl_out[0];
         sum_sat_ff <= term[0].sat | term[1].sat | term[2].sat | term[3].sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (en) begin
         rsp_valid <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (sum_oor_ff) begin
            rsp_interp_value <= '0;
            rsp_status       <= STATUS_RANGE;
         end else if (sum_ff > SUM_HI) begin
            rsp_interp_value <= SUM_HI[DATA_WIDTH-1:0];
            rsp_status       <= STATUS_SAT;
         end else if (sum_ff < SUM_LO) begin
            rsp_interp_value <= SUM_LO[DATA_WIDTH-1:0];
            rsp_status       <= STATUS_SAT;
         end else begin
            rsp_interp_value <= sum_ff[DATA_WIDTH-1:0];
            rsp_status       <= sum_sat_ff ? STATUS_SAT : STATUS_OK;
         end
      end
   end

`ifndef SYNTHESIS
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_RANGE)) |-> (rsp_interp_value == '0))
      else $error("out-of-range item with nonzero value");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v0_ff)
      else $error("accepted item did not enter the pipeline");

   a_hold_sum: assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(sum_valid_ff) && $stable(sum_ff)))
      else $error("pipeline moved while output stalled");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_lagrange_four_point_interpolator_top.sv =====
// Testbench for the four-point Lagrange interpolator: directed table, then random items
// under several idle/stall phases, each checked against its table entry or an in-bench fixed-point model.
// Depends on lfpi_pkg and lagrange_four_point_interpolator_top.
`default_nettype none

module tb_lagrange_four_point_interpolator_top;
   import lfpi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = 32;
   localparam int LATENCY = DW + 44;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [DW-1:0] x0, x1, x2, x3, y0, y1, y2, y3, q;
   } query_item;

   typedef struct packed {
      logic [DW-1:0] value;
      status_type    status;
   } interp_result;

   typedef struct {
      query_item  item;
      logic       fixed;
      interp_result want;
   } table_row;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   query_item req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [DW-1:0] rsp_interp_value;
   logic [1:0] rsp_status;

   lagrange_four_point_interpolator_top #(.DATA_WIDTH(DW)) dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_grid_x0(req_item.x0), .req_grid_x1(req_item.x1),
      .req_grid_x2(req_item.x2), .req_grid_x3(req_item.x3),
      .req_grid_y0(req_item.y0), .req_grid_y1(req_item.y1),
      .req_grid_y2(req_item.y2), .req_grid_y3(req_item.y3),
      .req_query_point(req_item.q),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_interp_value(rsp_interp_value), .rsp_status(rsp_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [15:0] spacing_cfg = '0;
   interp_result pending_results[$];
   int mismatches = 0;
   int checked = 0;
   int sat_seen = 0, range_seen = 0;
   int send_idle_pct = 0, recv_stall_pct = 0;
   longint cycles = 0;

   // round(x*y / 2^30), capped
   function automatic logic [63:0] scaled_product(input logic [63:0] x, input logic [63:0] y,
                                                  input logic [63:0] cap, inout logic sat);
      logic [127:0] p;
      p = ({64'd0, x} * {64'd0, y} + (128'd1 << (COEF_FRAC - 1))) >> COEF_FRAC;
      if (p > {64'd0, cap}) begin
         sat = 1'b1;
         return cap;
      end
      return p[63:0];
   endfunction

   function automatic interp_result interpolate(input query_item it, input logic [15:0] spc);
      longint x[4], y[4], a, sum, den, num, hi_lim, lo_lim;
      logic [63:0] mag, q, dm, nm, t;
      logic [127:0] qw;
      logic neg, sat;
      interp_result r;
      x[0] = longint'($signed(it.x0)); x[1] = longint'($signed(it.x1));
      x[2] = longint'($signed(it.x2)); x[3] = longint'($signed(it.x3));
      y[0] = longint'($signed(it.y0)); y[1] = longint'($signed(it.y1));
      y[2] = longint'($signed(it.y2)); y[3] = longint'($signed(it.y3));
      a = longint'($signed(it.q));
      sum = 0;
      sat = 1'b0;
      hi_lim = 64'sd2147483647;
      lo_lim = -64'sd2147483648;
      if (a < x[1] || a > x[2]) begin
         r.value = '0;
         r.status = STATUS_RANGE;
         return r;
      end
      for (int i = 0; i < 4; i++) begin
         mag = COEF_ONE;
         neg = 1'b0;
         for (int k = 0; k < 4; k++) begin
            if (k == i) continue;
            den = x[i] - x[k];
            dm = den < 0 ? -den : den;
            if (dm <= {48'd0, spc}) continue;
            num = a - x[k];
            nm = num < 0 ? -num : num;
            qw = (({64'd0, nm} << COEF_FRAC) + {64'd0, dm >> 1}) / {64'd0, dm};
            if (qw > {64'd0, COEF_CAP}) begin
               q = COEF_CAP;
               sat = 1'b1;
            end else q = qw[63:0];
            if (num != 0 && ((num < 0) != (den < 0))) neg = ~neg;
            mag = scaled_product(mag, q, COEF_CAP, sat);
         end
         t = scaled_product(mag, y[i] < 0 ? -y[i] : y[i], TERM_CAP, sat);
         if (neg != (y[i] < 0)) sum -= longint'(t);
         else sum += longint'(t);
      end
      if (sum > hi_lim) begin
         sum = hi_lim;
         sat = 1'b1;
      end else if (sum < lo_lim) begin
         sum = lo_lim;
         sat = 1'b1;
      end
      r.value = sum[DW-1:0];
      r.status = sat ? STATUS_SAT : STATUS_OK;
      return r;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, pending_results.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result checking
   always @(posedge clock) begin
      interp_result want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h/%0d", rsp_interp_value, rsp_status);
         end else begin
            want = pending_results.pop_front();
            checked++;
            if (rsp_status == STATUS_SAT) sat_seen++;
            if (rsp_status == STATUS_RANGE) range_seen++;
            if (rsp_interp_value !== want.value || rsp_status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h/%0d actual %h/%0d", want.value, want.status,
                           rsp_interp_value, rsp_status);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   task automatic send_item(input query_item it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      pending_results.push_back(interpolate(it, spacing_cfg));
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_and_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_spacing(input logic [15:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      spacing_cfg = v;
   endtask

   function automatic logic [DW-1:0] rand_word();
      case ($urandom_range(5))
         0: return 32'h8000_0000 | $urandom_range(3);
         1: return 32'h7FFF_FFFF - $urandom_range(3);
         2: return $urandom;
         default: return 32'($signed($urandom_range(2000000)) - 1000000);
      endcase
   endfunction

   // mostly in-range queries over ordered grids
   function automatic query_item rand_query();
      query_item it;
      logic [DW-1:0] lo, hi, tmp;
      int step;
      step = ($urandom_range(3) == 0) ? $urandom_range(20) : $urandom_range(300000);
      it.x1 = rand_word();
      if ($urandom_range(3) == 0) begin
         it.x2 = rand_word();
      end else begin
         it.x1 = 32'($signed($urandom_range(4000000)) - 2000000);
         it.x2 = it.x1 + step;
      end
      it.x0 = ($urandom_range(4) == 0) ? rand_word() : it.x1 - $urandom_range(300000);
      it.x3 = ($urandom_range(4) == 0) ? rand_word() : it.x2 + $urandom_range(300000);
      if ($urandom_range(9) == 0) it.x0 = it.x1 + $urandom_range(3);
      lo = it.x1;
      hi = it.x2;
      if ($signed(lo) > $signed(hi)) begin
         tmp = lo; lo = hi; hi = tmp;
      end
      if ($urandom_range(9) == 0) it.q = rand_word();
      else if ($urandom_range(5) == 0) it.q = $urandom_range(1) ? lo : hi;
      else it.q = DW'(64'(lo) + (64'($urandom) % (64'(hi - lo) + 64'd1)));
      it.y0 = rand_word(); it.y1 = rand_word(); it.y2 = rand_word(); it.y3 = rand_word();
      return it;
   endfunction

   localparam logic [DW-1:0] MAXV = 32'h7FFF_FFFF, MINV = 32'h8000_0000, ONE = 32'h0001_0000;
   table_row directed[] = '{
      '{'{0, ONE, 2*ONE, 3*ONE, 5, 6, 7, 8, 0}, 1'b1, '{32'd0, STATUS_RANGE}},
      '{'{0, ONE, 2*ONE, 3*ONE, 5, 6, 7, 8, 3*ONE}, 1'b1, '{32'd0, STATUS_RANGE}},
      '{'{0, 2*ONE, ONE, 3*ONE, 5, 6, 7, 8, ONE}, 1'b1, '{32'd0, STATUS_RANGE}},
      '{'{0, ONE, 2*ONE, 3*ONE, 5, 6, 7, 8, ONE}, 1'b1, '{32'd6, STATUS_OK}},
      '{'{0, ONE, 2*ONE, 3*ONE, 5, 6, 7, 8, 2*ONE}, 1'b1, '{32'd7, STATUS_OK}},
      '{'{0, ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE, 4*ONE, ONE + ONE/2}, 1'b0, '{0, STATUS_OK}},
      '{'{MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, MINV, 0}, 1'b0, '{0, STATUS_OK}},
      '{'{MINV, MINV, MAXV, MAXV, MINV, MAXV, MAXV, MINV, MAXV}, 1'b0, '{0, STATUS_OK}},
      '{'{MINV, -1, 0, MAXV, MAXV, MAXV, MAXV, MAXV, 0}, 1'b0, '{0, STATUS_OK}},
      '{'{0, 1, 2, 3, MAXV, MINV, MAXV, MINV, 1}, 1'b0, '{0, STATUS_OK}},
      '{'{-5, 0, 5, 7, MAXV, MAXV, MINV, MAXV, 3}, 1'b0, '{0, STATUS_OK}},
      '{'{ONE, ONE, ONE, ONE, 1, 2, 3, 4, ONE}, 1'b0, '{0, STATUS_OK}},
      '{'{ONE, ONE, ONE+1, ONE+2, -1, 1, -1, 1, ONE}, 1'b0, '{0, STATUS_OK}},
      '{'{-7*ONE, -ONE, 9*ONE, 40*ONE, 123456, -98765, 4321, -1, 2*ONE}, 1'b0, '{0, STATUS_OK}},
      '{'{MAXV, MINV, MAXV, MINV, MAXV, MAXV, MAXV, MAXV, MINV}, 1'b0, '{0, STATUS_OK}}
   };

   initial begin
      query_item it;
      int phase_pct[4][2] = '{'{0, 0}, '{72, 0}, '{0, 72}, '{25, 25}};
      logic [15:0] spacings[4] = '{16'd0, 16'd3, 16'd65535, 16'd1000};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[r]) begin
         if (directed[r].fixed) begin
            send_item(directed[r].item);
            pending_results[pending_results.size()-1] = directed[r].want;
         end else send_item(directed[r].item);
      end
      drain_and_idle();
      write_spacing(16'd65535);
      foreach (directed[r]) send_item(directed[r].item);
      drain_and_idle();
      for (int ph = 0; ph < 4; ph++) begin
         write_spacing(spacings[ph]);
         send_idle_pct = phase_pct[ph][0];
         recv_stall_pct = phase_pct[ph][1];
         for (int n = 0; n < 210; n++) begin
            if (n == 100) begin
               req_valid <= 1'b0;
               while (pending_results.size() != 0) @(posedge clock);
            end
            it = rand_query();
            send_item(it);
         end
         drain_and_idle();
      end
      recv_stall_pct = 0;
      $display("checked %0d results (%0d out of range, %0d saturated) over four spacings",
               checked, range_seen, sat_seen);
      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule

`default_nettype wire
